>>> rtl/dtw_pkg.sv
// DTW path distance: shared package.
// Types, codes and default sizes for the DTW block; no dependencies.
`timescale 1ns / 1ps
package dtw_pkg;
   localparam int MaxLenDefault     = 64;
   localparam int SampleBitsDefault = 16;
   localparam int DistBits          = 31;
   localparam int CostBits          = 48;

   typedef enum logic [1:0] {
      ACT_APPEND_A = 2'd0,
      ACT_APPEND_B = 2'd1,
      ACT_COMPUTE  = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_DROPPED = 2'd2
   } status_type;
endpackage

>>> rtl/dtw_path_distance_core.sv
// DTW path distance top level: sample stores, cost table, sequencer.
// Depends on dtw_pkg.
//
// Use: req_action/req_sample move one item per transfer. Appends produce no
// result. A compute item fills the N x M cost table cell by cell, each cell
// taking three table reads and one write (S_FRD0, S_FRD1, S_FRD2, S_FWR). It
// then reads the last cell in a first pass and walks back one step per pass
// through S_BRD0, S_BRD1, S_BRD2 and S_BSTEP, then presents the result.
// One result (rsp_distance, rsp_status) is presented per compute; req_stall
// is high while a compute runs or its result has not been taken. If the
// receiver holds rsp_stall the result stays and no new item is taken. Reset
// empties both sequences, clears the dropped flag and drops any result.
// An empty sequence gives distance 0, status 1 in the next cycle; dropped
// samples give status 2. Distances saturate to 2^31-1.
`timescale 1ns / 1ps
module dtw_path_distance_core #(
   parameter int MAX_LEN     = dtw_pkg::MaxLenDefault,
   parameter int SAMPLE_BITS = dtw_pkg::SampleBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_action,
   input  logic signed [15:0]          req_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dtw_pkg::DistBits-1:0] rsp_distance,
   output logic [1:0]                  rsp_status
);
   import dtw_pkg::*;

   localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int TD = MAX_LEN * MAX_LEN;
   localparam int TW = $clog2(TD);
   localparam int SB = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_FRD0  = 10'b0000000010,
      S_FRD1  = 10'b0000000100,
      S_FRD2  = 10'b0000001000,
      S_FWR   = 10'b0000010000,
      S_BRD0  = 10'b0000100000,
      S_BRD1  = 10'b0001000000,
      S_BRD2  = 10'b0010000000,
      S_BSTEP = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic signed [SB-1:0] seq_a [MAX_LEN];
   logic signed [SB-1:0] seq_b [MAX_LEN];
   logic [CostBits-1:0]  table_mem [TD];
   logic [CW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic drop_ff, drop_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic [CostBits-1:0] rd_ff, up_ff, up_in, left_ff, left_in, best_ff, best_in;
   logic [CostBits-1:0] total_ff, total_in;
   logic signed [SB-1:0] sa_ff, sb_ff;
   logic [1:0] dir_ff, dir_in;  // 3 marks the first pass of the walk
   logic [DistBits-1:0] dist_ff, dist_in;
   logic [1:0] stat_ff, stat_in;
   logic vld_ff, vld_in;
   logic [TW-1:0] raddr, waddr;
   logic          we;
   logic [CostBits-1:0] wdata;
   logic [CostBits-1:0] best3;
   logic signed [SB:0] diff;
   logic [SB:0]   adiff;
   logic          acc;
   logic          last_i, last_j;

   assign acc       = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || vld_ff;
   assign rsp_valid = vld_ff;
   assign rsp_distance = dist_ff;
   assign rsp_status   = stat_ff;

   function automatic logic [TW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
      logic [2*IW:0] p;
      p = (2*IW+1)'(r * MAX_LEN + c);
      return p[TW-1:0];
   endfunction

   assign last_i = (CW'(i_ff) == cnt_a_ff - CW'(1));
   assign last_j = (CW'(j_ff) == cnt_b_ff - CW'(1));
   assign diff   = {sa_ff[SB-1], sa_ff} - {sb_ff[SB-1], sb_ff};
   assign adiff  = diff[SB] ? (SB+1)'(-diff) : diff;
   assign waddr  = addr(i_ff, j_ff);
   assign we     = (state_ff == S_FWR);
   // diag read lands in rd_ff during S_FWR; fold it into the minimum here
   assign best3  = (i_ff != '0 && j_ff != '0 && rd_ff < best_ff) ? rd_ff : best_ff;
   assign wdata  = (i_ff == '0 && j_ff == '0) ? '0
                   : best3 + CostBits'(adiff);

   always_comb begin
      raddr = addr(i_ff, j_ff);
      unique case (state_ff)
         S_FRD0:  raddr = addr(i_ff - IW'(1), j_ff);
         S_FRD1:  raddr = addr(i_ff, j_ff - IW'(1));
         S_FRD2:  raddr = addr(i_ff - IW'(1), j_ff - IW'(1));
         S_BRD0:  raddr = addr(i_ff - IW'(1), j_ff);
         S_BRD1:  raddr = addr(i_ff, j_ff - IW'(1));
         S_BRD2:  raddr = (dir_ff == 2'd3) ? addr(i_ff, j_ff)
                          : addr(i_ff - IW'(1), j_ff - IW'(1));
         default: raddr = addr(i_ff, j_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) table_mem[waddr] <= wdata;
      rd_ff <= table_mem[raddr];
      sa_ff <= seq_a[i_ff];
      sb_ff <= seq_b[j_ff];
      if (acc && action_type'(req_action) == ACT_APPEND_A && cnt_a_ff < CW'(MAX_LEN))
         seq_a[cnt_a_ff[IW-1:0]] <= req_sample[SB-1:0];
      if (acc && action_type'(req_action) == ACT_APPEND_B && cnt_b_ff < CW'(MAX_LEN))
         seq_b[cnt_b_ff[IW-1:0]] <= req_sample[SB-1:0];
   end

   // rd_ff holds the read issued in the previous state.
   always_comb begin
      state_in = state_ff;
      cnt_a_in = cnt_a_ff;  cnt_b_in = cnt_b_ff;  drop_in = drop_ff;
      i_in = i_ff;  j_in = j_ff;
      up_in = up_ff;  left_in = left_ff;  best_in = best_ff;
      total_in = total_ff;  dir_in = dir_ff;
      dist_in = dist_ff;  stat_in = stat_ff;
      vld_in = vld_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               unique case (action_type'(req_action))
                  ACT_APPEND_A: if (cnt_a_ff < CW'(MAX_LEN)) cnt_a_in = cnt_a_ff + CW'(1);
                                else drop_in = 1'b1;
                  ACT_APPEND_B: if (cnt_b_ff < CW'(MAX_LEN)) cnt_b_in = cnt_b_ff + CW'(1);
                                else drop_in = 1'b1;
                  ACT_COMPUTE: begin
                     if (cnt_a_ff == '0 || cnt_b_ff == '0) begin
                        dist_in = '0;  stat_in = ST_EMPTY;  vld_in = 1'b1;
                        cnt_a_in = '0;  cnt_b_in = '0;  drop_in = 1'b0;
                     end else begin
                        i_in = '0;  j_in = '0;  state_in = S_FRD0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FRD0: state_in = S_FRD1;
         S_FRD1: begin up_in = rd_ff; state_in = S_FRD2; end
         S_FRD2: begin left_in = rd_ff; state_in = S_FWR;
            if (i_ff == '0) best_in = rd_ff;       // left only
            else if (j_ff == '0) best_in = up_ff;  // up only
         end
         S_FWR: begin
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  j_in = j_ff; state_in = S_BRD0;
               end else begin
                  i_in = i_ff + IW'(1); state_in = S_FRD0;
               end
            end else begin
               j_in = j_ff + IW'(1); state_in = S_FRD0;
            end
         end
         S_BRD0: state_in = S_BRD1;
         S_BRD1: begin up_in = rd_ff; state_in = S_BRD2; end
         S_BRD2: begin left_in = rd_ff; state_in = S_BSTEP; end
         S_BSTEP: begin
            // rd_ff: diag, or current cell on the first pass of the walk
            if (dir_ff == 2'd3) begin
               total_in = rd_ff; dir_in = 2'd0;
            end else if (j_ff == '0) begin
               total_in = total_ff + up_ff; i_in = i_ff - IW'(1);
            end else if (i_ff == '0) begin
               total_in = total_ff + left_ff; j_in = j_ff - IW'(1);
            end else if (up_ff <= left_ff && up_ff <= rd_ff) begin
               total_in = total_ff + up_ff; i_in = i_ff - IW'(1);
            end else if (left_ff <= rd_ff) begin
               total_in = total_ff + left_ff; j_in = j_ff - IW'(1);
            end else begin
               total_in = total_ff + rd_ff;
               i_in = i_ff - IW'(1); j_in = j_ff - IW'(1);
            end
            if (dir_ff != 2'd3 && i_in == '0 && j_in == '0) state_in = S_OUT;
            else if (dir_ff == 2'd3 && i_ff == '0 && j_ff == '0) state_in = S_OUT;
            else state_in = S_BRD0;
         end
         S_OUT: begin
            dist_in = (total_ff > CostBits'({DistBits{1'b1}})) ? {DistBits{1'b1}}
                      : total_ff[DistBits-1:0];
            stat_in = drop_ff ? ST_DROPPED : ST_OK;
            vld_in = 1'b1;
            cnt_a_in = '0;  cnt_b_in = '0;  drop_in = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // min of up and left; diag joins at the write
      if (state_ff == S_FRD2 && i_ff != '0 && j_ff != '0) begin
         best_in = (rd_ff < up_ff) ? rd_ff : up_ff;
      end
      if (state_ff == S_FWR && last_j && last_i) dir_in = 2'd3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_a_ff <= '0;  cnt_b_ff <= '0;  drop_ff <= 1'b0;  vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;  cnt_b_ff <= cnt_b_in;
         drop_ff <= drop_in;  vld_ff <= vld_in;
      end
      i_ff <= i_in;  j_ff <= j_in;
      up_ff <= up_in;  left_ff <= left_in;
      best_ff <= best_in;
      total_ff <= total_in;  dir_ff <= dir_in;
      dist_ff <= dist_in;  stat_ff <= stat_in;
   end
endmodule

>>> verif/tb.sv
// Testbench for dtw_path_distance_core: drives append and compute transfers
// and checks each result against an in-bench DTW predictor. Depends on dtw_pkg.
`timescale 1ns / 1ps
module tb;
   import dtw_pkg::*;

   localparam int LEN = 64;
   localparam int WDOG_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_action = ACT_NONE;
   logic signed [15:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DistBits-1:0] rsp_distance;
   logic [1:0] rsp_status;

   dtw_path_distance_core dut (.*);

   typedef struct packed {
      logic [1:0] action;
      logic signed [15:0] sample;
   } req_item_type;

   typedef struct packed {
      logic [DistBits-1:0] distance;
      logic [1:0] status;
   } dtw_result_type;

   req_item_type pending_q[$];
   dtw_result_type expected_q[$];
   int errors = 0;
   int computes = 0;
   bit hold_rsp = 0;
   int idle_cycles = 0;
   bit took = 0;

   // predictor state
   logic signed [15:0] seq_a[LEN];
   logic signed [15:0] seq_b[LEN];
   int cnt_a = 0, cnt_b = 0;
   bit dropped = 0;
   longint unsigned cost[LEN][LEN];

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned path_distance(int n, int m);
      longint unsigned best, total, up, lf, dg;
      longint signed d;
      int i, j;
      for (i = 0; i < n; i++) begin
         for (j = 0; j < m; j++) begin
            d = longint'(seq_a[i]) - longint'(seq_b[j]);
            if (d < 0) d = -d;
            if (i == 0 && j == 0) best = 0;
            else if (i == 0) best = cost[0][j-1];
            else if (j == 0) best = cost[i-1][0];
            else begin
               best = cost[i-1][j];
               if (cost[i][j-1] < best) best = cost[i][j-1];
               if (cost[i-1][j-1] < best) best = cost[i-1][j-1];
            end
            cost[i][j] = (i == 0 && j == 0) ? 0 : longint'(d) + best;
         end
      end
      i = n - 1;
      j = m - 1;
      total = cost[i][j];
      while (i != 0 || j != 0) begin
         if (j == 0) begin
            total += cost[i-1][j]; i--;
         end else if (i == 0) begin
            total += cost[i][j-1]; j--;
         end else begin
            up = cost[i-1][j]; lf = cost[i][j-1]; dg = cost[i-1][j-1];
            if (up <= lf && up <= dg) begin
               total += up; i--;
            end else if (lf <= dg) begin
               total += lf; j--;
            end else begin
               total += dg; i--; j--;
            end
         end
      end
      return total;
   endfunction

   task automatic predict_transfer(req_item_type it);
      dtw_result_type r;
      longint unsigned path_dist;
      case (it.action)
         ACT_APPEND_A: begin
            if (cnt_a < LEN) seq_a[cnt_a++] = it.sample;
            else dropped = 1;
         end
         ACT_APPEND_B: begin
            if (cnt_b < LEN) seq_b[cnt_b++] = it.sample;
            else dropped = 1;
         end
         ACT_COMPUTE: begin
            if (cnt_a == 0 || cnt_b == 0) begin
               r.distance = '0;
               r.status = ST_EMPTY;
            end else begin
               path_dist = path_distance(cnt_a, cnt_b);
               if (path_dist > 64'h7FFF_FFFF) path_dist = 64'h7FFF_FFFF;
               r.distance = path_dist[DistBits-1:0];
               r.status = dropped ? ST_DROPPED : ST_OK;
            end
            expected_q.push_back(r);
            cnt_a = 0; cnt_b = 0; dropped = 0;
         end
         default: ;
      endcase
   endtask

   function automatic int gap_len();
      int p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'($urandom_range(7));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push(logic [1:0] a, logic signed [15:0] s);
      req_item_type it;
      it.action = a;
      it.sample = s;
      pending_q.push_back(it);
   endtask

   task automatic push_seq(int na, int nb, bit big);
      for (int k = 0; k < na || k < nb; k++) begin
         if (k < na) push(ACT_APPEND_A, big ? rand_sample() : 16'($urandom_range(20)) - 16'sd10);
         if (k < nb) push(ACT_APPEND_B, big ? rand_sample() : 16'($urandom_range(20)) - 16'sd10);
      end
      push(ACT_COMPUTE, 16'($urandom));
   endtask

   // driver
   int drv_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || took) begin
            if (drv_gap > 0) begin
               drv_gap <= drv_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_item_type it;
               it = pending_q.pop_front();
               req_action <= it.action;
               req_sample <= it.sample;
               req_valid <= 1'b1;
               drv_gap <= gap_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // acceptance seen at the rising edge
   always @(posedge clock) begin
      took <= 1'b0;
      if (!reset && req_valid && !req_stall) begin
         req_item_type it;
         it.action = req_action;
         it.sample = req_sample;
         predict_transfer(it);
         took <= 1'b1;
      end
   end

   // receiver stall
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         rsp_gap <= ($urandom_range(3) == 0) ? gap_len() : 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result distance=%0d status=%0d",
                     $realtime, rsp_distance, rsp_status);
            errors++;
         end else begin
            dtw_result_type e;
            e = expected_q.pop_front();
            computes++;
            if (rsp_distance !== e.distance) begin
               $display("%0t: distance mismatch expected %0d actual %0d",
                        $realtime, e.distance, rsp_distance);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status mismatch expected %0d actual %0d",
                        $realtime, e.status, rsp_status);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_rsp)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      int n;
      wait (computes >= 3);
      @(negedge clock);
      hold_rsp = 1;
      n = 0;
      while (n < 3000) begin
         @(negedge clock);
         n++;
      end
      hold_rsp = 0;
   end

   initial begin
      int n_items;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      push(ACT_COMPUTE, 16'sh0);                 // both empty
      push(ACT_APPEND_A, 16'sh7FFF);
      push(ACT_COMPUTE, 16'shFFFF);              // second empty
      push(ACT_APPEND_A, 16'sh7FFF);
      push(ACT_APPEND_B, 16'sh8000);
      push(ACT_COMPUTE, 16'sh0);                 // single cell, extreme diff
      push(ACT_NONE, 16'sh1234);                 // ignored
      push(ACT_APPEND_A, 16'sh8000);
      push(ACT_APPEND_A, 16'sh7FFF);
      push(ACT_APPEND_B, 16'sh7FFF);
      push(ACT_NONE, 16'shFFFF);
      push(ACT_APPEND_B, 16'sh8000);
      push(ACT_APPEND_B, 16'sh0);
      push(ACT_COMPUTE, 16'sh5555);
      push(ACT_APPEND_B, 16'sh1);
      push(ACT_COMPUTE, 16'shAAAA);              // first empty
      // full sequences with overflow drop, largest extreme values
      for (int k = 0; k < LEN + 2; k++) push(ACT_APPEND_A, (k % 2) ? 16'sh7FFF : 16'sh8000);
      for (int k = 0; k < LEN + 1; k++) push(ACT_APPEND_B, (k % 2) ? 16'sh8000 : 16'sh7FFF);
      push(ACT_COMPUTE, 16'sh0);
      push_seq(3, 2, 1);

      // random: mostly short well-formed sequences, some noise
      n_items = 0;
      while (n_items < 1600) begin
         int na, nb, p;
         p = $urandom_range(99);
         if (p < 5) begin
            push(ACT_NONE, 16'($urandom)); n_items++;
         end else if (p < 10) begin
            push(ACT_COMPUTE, 16'($urandom)); n_items++;
         end else begin
            na = (p < 13) ? $urandom_range(LEN, 40) : $urandom_range(8);
            nb = (p < 13) ? $urandom_range(LEN, 40) : $urandom_range(8);
            if (p >= 13 && $urandom_range(15) == 0) nb = LEN + 1;
            push_seq(na, nb, 1'($urandom_range(1)));
            n_items += na + nb + 1;
         end
      end

      wait (pending_q.size() == 0 && !req_valid && expected_q.size() == 0);
      repeat (100) @(posedge clock);
      $display("Covered %0d compute results over %0d stimulus items, including",
               computes, n_items);
      $display("empty, dropped-sample, extreme-value and ignored-action cases.");
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
